// ===== rtl/core/srq_pkg.sv =====
// Shared types, constants and the compare function for the sparse-table
// range extreme query core. No dependencies.
package srq_pkg;

    localparam int CAPACITY = 1024;
    localparam int LEVELS   = 11;
    localparam int VALUE_W  = 32;

    localparam int IDX_W  = $clog2(CAPACITY);      // entry index within a level
    localparam int CNT_W  = IDX_W + 1;             // element count, 1-based index
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DEPTH  = LEVELS * CAPACITY;
    localparam int QB_W   = $clog2(CNT_W);         // floor log2 of a range length
    localparam int SUM_W  = CNT_W + LEVELS;        // entry index plus block step

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BUILD = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CNT_W-1:0]          index;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } mem_rd_t;

    // True when b beats a: min mode ties go to the smaller index,
    // max mode ties to the larger one.
    function automatic logic take_second(input entry_t a, input entry_t b,
                                         input logic sel_min);
        logic lt;
        logic gt;
        logic eq;
        begin
            lt = b.value < a.value;
            gt = b.value > a.value;
            eq = b.value == a.value;
            if (sel_min)
            begin
                take_second = lt || (eq && (b.index < a.index));
            end
            else
            begin
                take_second = gt || (eq && (b.index > a.index));
            end
        end
    endfunction

endpackage

// ===== rtl/core/srq_if.sv =====
// Handshake channels of the range extreme query core: request, response
// and mode configuration. Depends on srq_pkg.
interface srq_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         func;
    logic signed [srq_pkg::VALUE_W-1:0] element_value;
    logic [srq_pkg::CNT_W-1:0]          left_index;
    logic [srq_pkg::CNT_W-1:0]          right_index;

    modport source (output valid, func, element_value, left_index, right_index,
                    input ready);
    modport sink   (input valid, func, element_value, left_index, right_index,
                    output ready);
endinterface

interface srq_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [srq_pkg::VALUE_W-1:0] extreme_value;
    logic [srq_pkg::CNT_W-1:0]          extreme_index;
    logic                               status;

    modport source (output valid, extreme_value, extreme_index, status,
                    input ready);
    modport sink   (input valid, extreme_value, extreme_index, status,
                    output ready);
endinterface

interface srq_cfg_if;
    logic valid;
    logic ready;
    logic select_minimum;

    modport source (output valid, select_minimum, input ready);
    modport sink   (input valid, select_minimum, output ready);
endinterface

// ===== rtl/core/srq_level_mem.sv =====
// Level table storage: one write port, two registered read ports.
// Address is {level, entry}. Depends on srq_pkg.
module srq_level_mem (
    input  logic             clk,
    input  srq_pkg::mem_wr_t wr,
    input  srq_pkg::mem_rd_t rd,
    output srq_pkg::entry_t  rd_a_data,
    output srq_pkg::entry_t  rd_b_data
);

    srq_pkg::entry_t mem [srq_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_data <= mem[rd.addr_a];
        rd_b_data <= mem[rd.addr_b];
    end

endmodule

// ===== rtl/core/sparse_table_range_extreme_query_core.sv =====
// Sparse-table range maximum / minimum query core.
// Depends on srq_pkg, srq_if and srq_level_mem.
//
// Channels: req carries one command per beat (load, build, query), rsp
// returns exactly one result beat per command, cfg writes select_minimum
// (0 = maximum, 1 = minimum) and always accepts; a write drops the built
// table. Write cfg only while the core is idle.
// Command handling, one command at a time:
//   load   written straight into level 0 of the table
//   query  both block entries are read in the accept cycle and
//          compared when the memory data returns
//   build  for n loaded elements, each entry of each level above 0
//          passes through a read state and a compare/write state on
//          the single compare unit and the one table write port
//   bad or unknown commands answer with status 1.
// req.ready is low while a build or query is in progress, and also while a
// finished result sits in the output register and rsp.ready is low; the
// result is held until taken. After reset the table is empty and unbuilt,
// minimum mode is off, and no clearing pass is needed.
module sparse_table_range_extreme_query_core (
    input  logic      clk,
    input  logic      rst_n,
    srq_in_if.sink    req,
    srq_out_if.source rsp,
    srq_cfg_if.sink   cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BRD  = 3'd1;
    localparam logic [2:0] S_BWR  = 3'd2;
    localparam logic [2:0] S_QCMP = 3'd3;

    logic [2:0]                  state_reg, state_next;
    logic [srq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        built_reg, built_next;
    logic                        sel_min_reg, sel_min_next;
    logic [srq_pkg::LVL_W-1:0]   lvl_reg, lvl_next;
    logic [srq_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        use_b_reg, use_b_next;

    logic                               out_valid_reg, out_valid_next;
    logic signed [srq_pkg::VALUE_W-1:0] out_value_reg;
    logic [srq_pkg::CNT_W-1:0]          out_index_reg;
    logic                               out_status_reg;

    logic                               res_valid;
    logic signed [srq_pkg::VALUE_W-1:0] res_value;
    logic [srq_pkg::CNT_W-1:0]          res_index;
    logic                               res_status;

    logic             acc;
    srq_pkg::mem_wr_t wr;
    srq_pkg::mem_rd_t rd;
    srq_pkg::entry_t  rd_a_data;
    srq_pkg::entry_t  rd_b_data;
    srq_pkg::entry_t  best;
    logic             pick_b;

    // query decode
    logic [srq_pkg::CNT_W-1:0]  q_len;
    logic [srq_pkg::QB_W-1:0]   q_b;
    logic [srq_pkg::CNT_W-1:0]  q_pow;
    logic                       q_bad;
    logic [srq_pkg::LVL_W-1:0]  q_lvl;
    logic [srq_pkg::ADDR_W-1:0] q_addr_a;
    logic [srq_pkg::ADDR_W-1:0] q_addr_b;

    // build addressing
    logic [srq_pkg::LVL_W-1:0]  lvl_prev;
    logic [srq_pkg::SUM_W-1:0]  bld_sum;

    srq_level_mem u_mem (
        .clk       (clk),
        .wr        (wr),
        .rd        (rd),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.extreme_value = out_value_reg;
    assign rsp.extreme_index = out_index_reg;
    assign rsp.status        = out_status_reg;

    always_comb
    begin
        q_len = req.right_index - req.left_index + srq_pkg::CNT_W'(1);
        q_b   = '0;
        for (int k = 0; k < srq_pkg::CNT_W; k++)
        begin
            if (q_len[k])
            begin
                q_b = srq_pkg::QB_W'(k);
            end
        end
        q_pow = srq_pkg::CNT_W'(1) << q_b;
        q_lvl = srq_pkg::LVL_W'(q_b);
        q_bad = !built_reg
             || (req.left_index == '0)
             || (req.right_index < req.left_index)
             || (req.right_index > count_reg)
             || ({1'b0, q_b} >= (srq_pkg::QB_W + 1)'(srq_pkg::LEVELS));
        q_addr_a = {q_lvl, srq_pkg::IDX_W'(req.left_index - srq_pkg::CNT_W'(1))};
        q_addr_b = {q_lvl, srq_pkg::IDX_W'(req.right_index - q_pow)};
    end

    assign lvl_prev = lvl_reg - srq_pkg::LVL_W'(1);
    assign bld_sum  = srq_pkg::SUM_W'(idx_reg)
                    + (srq_pkg::SUM_W'(1) << lvl_prev);

    always_comb
    begin
        if (state_reg == S_BRD)
        begin
            rd.addr_a = {lvl_prev, idx_reg};
            rd.addr_b = {lvl_prev, bld_sum[srq_pkg::IDX_W-1:0]};
        end
        else
        begin
            rd.addr_a = q_addr_a;
            rd.addr_b = q_addr_b;
        end
    end

    // the one compare unit, shared by build and query
    assign pick_b = ((state_reg == S_QCMP) || use_b_reg)
                 && srq_pkg::take_second(rd_a_data, rd_b_data, sel_min_reg);
    assign best   = pick_b ? rd_b_data : rd_a_data;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        built_next   = built_reg;
        sel_min_next = sel_min_reg;
        lvl_next     = lvl_reg;
        idx_next     = idx_reg;
        use_b_next   = use_b_reg;
        wr           = '0;
        res_valid    = 1'b0;
        res_value    = '0;
        res_index    = '0;
        res_status   = srq_pkg::STATUS_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.func)
                        srq_pkg::FUNC_LOAD:
                        begin
                            res_valid = 1'b1;
                            if (count_reg >= srq_pkg::CNT_W'(srq_pkg::CAPACITY))
                            begin
                                res_status = srq_pkg::STATUS_ERR;
                            end
                            else
                            begin
                                wr.en         = 1'b1;
                                wr.addr       = {srq_pkg::LVL_W'(0),
                                                 count_reg[srq_pkg::IDX_W-1:0]};
                                wr.data.value = req.element_value;
                                wr.data.index = count_reg + srq_pkg::CNT_W'(1);
                                count_next    = count_reg + srq_pkg::CNT_W'(1);
                                built_next    = 1'b0;
                            end
                        end
                        srq_pkg::FUNC_BUILD:
                        begin
                            if (count_reg == '0)
                            begin
                                built_next = 1'b1;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                lvl_next   = srq_pkg::LVL_W'(1);
                                idx_next   = '0;
                                state_next = S_BRD;
                            end
                        end
                        srq_pkg::FUNC_QUERY:
                        begin
                            if (q_bad)
                            begin
                                res_valid  = 1'b1;
                                res_status = srq_pkg::STATUS_ERR;
                            end
                            else
                            begin
                                state_next = S_QCMP;
                            end
                        end
                        default:
                        begin
                            res_valid  = 1'b1;
                            res_status = srq_pkg::STATUS_ERR;
                        end
                    endcase
                end
            end
            S_BRD:
            begin
                use_b_next = bld_sum < srq_pkg::SUM_W'(count_reg);
                state_next = S_BWR;
            end
            S_BWR:
            begin
                wr.en   = 1'b1;
                wr.addr = {lvl_reg, idx_reg};
                wr.data = best;
                if (srq_pkg::CNT_W'(idx_reg) == count_reg - srq_pkg::CNT_W'(1))
                begin
                    idx_next = '0;
                    if (lvl_reg == srq_pkg::LVL_W'(srq_pkg::LEVELS - 1))
                    begin
                        built_next = 1'b1;
                        res_valid  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + srq_pkg::LVL_W'(1);
                        state_next = S_BRD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + srq_pkg::IDX_W'(1);
                    state_next = S_BRD;
                end
            end
            S_QCMP:
            begin
                res_valid  = 1'b1;
                res_value  = best.value;
                res_index  = best.index;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.valid && cfg.ready)
        begin
            sel_min_next = cfg.select_minimum;
            built_next   = 1'b0;
        end
    end

    assign out_valid_next = (out_valid_reg && !rsp.ready) || res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            built_reg     <= 1'b0;
            sel_min_reg   <= 1'b0;
            lvl_reg       <= '0;
            idx_reg       <= '0;
            use_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            built_reg     <= built_next;
            sel_min_reg   <= sel_min_next;
            lvl_reg       <= lvl_next;
            idx_reg       <= idx_next;
            use_b_reg     <= use_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_value_reg  <= res_value;
            out_index_reg  <= res_index;
            out_status_reg <= res_status;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= srq_pkg::CNT_W'(srq_pkg::CAPACITY))
        else $error("element count past capacity");

    a_build_write_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BWR) |->
            ((srq_pkg::CNT_W'(idx_reg) < count_reg) && (lvl_reg != '0)))
        else $error("build writes outside the loaded entries or into level 0");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QCMP || state_reg == S_BWR) |-> !out_valid_reg)
        else $error("result produced while output register still full");

    a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.func == srq_pkg::FUNC_QUERY) |=>
            (state_reg == S_QCMP || out_valid_reg))
        else $error("accepted query neither compared nor answered");

endmodule

// ===== tb/srq_checker.sv =====
// Checker for the sparse-table range extreme query core: watches the request,
// result and mode channels, predicts every result and compares it.
// Depends on srq_pkg and srq_if.
module srq_checker (
    input  logic clk,
    input  logic rst_n,
    srq_in_if    req,
    srq_out_if   rsp,
    srq_cfg_if   cfg,
    output int   outstanding,
    output int   error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [srq_pkg::VALUE_W-1:0] value;
        logic [srq_pkg::CNT_W-1:0]          index;
        logic                               status;
    } answer_t;

    logic signed [srq_pkg::VALUE_W-1:0] loaded_values [1:srq_pkg::CAPACITY];
    int                                 held_count = 0;
    bit                                 table_ready = 1'b0;
    bit                                 minimum_mode = 1'b0;
    answer_t                            expected_answers [$];

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        error_count++;
        $display("%0t ns mismatch: %s got %0h want %0h", $time, what, seen, wanted);
    endtask

    // Advances the store and the built flag by one request beat and returns
    // the answer it must produce.
    function automatic answer_t predict_answer(
        input logic [1:0]                         op,
        input logic signed [srq_pkg::VALUE_W-1:0] value,
        input logic [srq_pkg::CNT_W-1:0]          lo,
        input logic [srq_pkg::CNT_W-1:0]          hi);
        answer_t                            ans;
        logic signed [srq_pkg::VALUE_W-1:0] best_value;
        logic [srq_pkg::CNT_W-1:0]          best_index;
        int                                 k;
        ans = '0;
        ans.status = srq_pkg::STATUS_OK;
        case (op)
            srq_pkg::FUNC_LOAD:
            begin
                if (held_count >= srq_pkg::CAPACITY)
                begin
                    ans.status = srq_pkg::STATUS_ERR;
                end
                else
                begin
                    held_count++;
                    loaded_values[held_count] = value;
                    table_ready = 1'b0;
                end
            end
            srq_pkg::FUNC_BUILD:
            begin
                table_ready = 1'b1;
            end
            srq_pkg::FUNC_QUERY:
            begin
                if (!table_ready || lo == 0 || hi < lo || hi > held_count)
                begin
                    ans.status = srq_pkg::STATUS_ERR;
                end
                else
                begin
                    best_value = loaded_values[lo];
                    best_index = lo;
                    // scan runs upward, so a tie moves the winner only in max mode
                    for (k = lo + 1; k <= hi; k++)
                    begin
                        if (minimum_mode ? (loaded_values[k] < best_value)
                                         : (loaded_values[k] >= best_value))
                        begin
                            best_value = loaded_values[k];
                            best_index = srq_pkg::CNT_W'(k);
                        end
                    end
                    ans.value = best_value;
                    ans.index = best_index;
                end
            end
            default:
            begin
                ans.status = srq_pkg::STATUS_ERR;
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin : watch_beats
        answer_t want;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                minimum_mode = cfg.select_minimum;
                table_ready = 1'b0;
            end
            if (req.valid && req.ready)
            begin
                expected_answers.push_back(predict_answer(req.func, req.element_value,
                                                          req.left_index, req.right_index));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending",
                                    64'({rsp.extreme_value, rsp.extreme_index, rsp.status}),
                                    '0);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    end
                    if (rsp.extreme_value !== want.value)
                    begin
                        report_mismatch("extreme_value", 64'(rsp.extreme_value),
                                        64'(want.value));
                    end
                    if (rsp.extreme_index !== want.index)
                    begin
                        report_mismatch("extreme_index", 64'(rsp.extreme_index),
                                        64'(want.index));
                    end
                end
            end
            outstanding <= expected_answers.size();
        end
    end

endmodule

// ===== tb/tb_sparse_table_range_extreme_query_core.sv =====
// Top of the range extreme query testbench: clock, reset, request and mode
// stimulus, result-side stalls and the verdict.
// Depends on srq_pkg, srq_if, srq_checker and the core.
module tb_sparse_table_range_extreme_query_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam int         IDLE_PCT      = 36;

    logic clk;
    logic rst_n;
    bit   steady;       // no idling on either side while set
    int   loaded;
    bit   built;
    int   issued;
    int   outstanding;
    int   error_count;

    srq_in_if  req_ch ();
    srq_out_if rsp_ch ();
    srq_cfg_if cfg_ch ();

    sparse_table_range_extreme_query_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    srq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .outstanding (outstanding),
        .error_count (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic issue_cmd(input logic [1:0] op,
                             input logic signed [srq_pkg::VALUE_W-1:0] value,
                             input int lo, input int hi);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= op;
        req_ch.element_value <= value;
        req_ch.left_index    <= srq_pkg::CNT_W'(lo);
        req_ch.right_index   <= srq_pkg::CNT_W'(hi);
        do @(posedge clk); while (!req_ch.ready);
        issued++;
        if (op == srq_pkg::FUNC_LOAD && loaded < srq_pkg::CAPACITY)
        begin
            loaded++;
            built = 1'b0;
        end
        else if (op == srq_pkg::FUNC_BUILD)
        begin
            built = 1'b1;
        end
    endtask

    task automatic wait_drained(input int settle);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_mode(input bit sel_min);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.select_minimum <= sel_min;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        built = 1'b0;
    endtask

    function automatic logic signed [srq_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                return $urandom_range(0, 6) - 3;    // narrow spread, lots of ties
            end
            3:
            begin
                return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default:
            begin
                return $urandom;
            end
        endcase
    endfunction

    // In-range query, mostly short or near a power of two in length.
    task automatic query_inside();
        int span;
        int lo;
        case ($urandom_range(0, 3))
            0:
            begin
                span = $urandom_range(1, (loaded < 4) ? loaded : 4);
            end
            1:
            begin
                span = (1 << $urandom_range(0, 10)) + $urandom_range(0, 2) - 1;
                if (span < 1)
                    span = 1;
                if (span > loaded)
                    span = loaded;
            end
            default:
            begin
                span = $urandom_range(1, loaded);
            end
        endcase
        lo = $urandom_range(1, loaded - span + 1);
        issue_cmd(srq_pkg::FUNC_QUERY, random_value(), lo, lo + span - 1);
    endtask

    task automatic stray_cmd();
        int lo;
        case ($urandom_range(0, 4))
            0:
            begin
                issue_cmd(FUNC_RESERVED, $urandom, $urandom_range(0, 2047),
                          $urandom_range(0, 2047));
            end
            1:
            begin
                issue_cmd(srq_pkg::FUNC_QUERY, $urandom, $urandom_range(0, 2047),
                          $urandom_range(0, 2047));
            end
            2:
            begin
                lo = $urandom_range(2, 2047);
                issue_cmd(srq_pkg::FUNC_QUERY, $urandom, lo, $urandom_range(1, lo - 1));
            end
            3:
            begin
                issue_cmd(srq_pkg::FUNC_QUERY, $urandom, 0, $urandom_range(0, loaded));
            end
            default:
            begin
                // unless the store is full, a late load drops the table and the query behind it must fail
                issue_cmd(srq_pkg::FUNC_LOAD, random_value(), 0, 0);
                issue_cmd(srq_pkg::FUNC_QUERY, $urandom, 1, 1);
            end
        endcase
    endtask

    initial
    begin : stimulus
        int phase;
        int n_loads;
        int n_queries;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= srq_pkg::FUNC_LOAD;
        req_ch.element_value  <= '0;
        req_ch.left_index     <= '0;
        req_ch.right_index    <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.select_minimum <= 1'b0;
        steady = 1'b0;
        loaded = 0;
        built  = 1'b0;
        issued = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b0);

        // empty store: query before build, empty build, query after it
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 1);
        issue_cmd(srq_pkg::FUNC_BUILD, 0, 0, 0);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 1);
        issue_cmd(FUNC_RESERVED, 32'hFFFF_FFFF, 2047, 2047);
        issue_cmd(srq_pkg::FUNC_LOAD, 32'h7FFF_FFFF, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, 32'h8000_0000, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, 0, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, -1, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, 32'h7FFF_FFFF, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, 32'h8000_0000, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, 5, 0, 0);
        issue_cmd(srq_pkg::FUNC_LOAD, 5, 0, 0);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 8);    // loads dropped the empty build
        issue_cmd(srq_pkg::FUNC_BUILD, 0, 0, 0);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 8);    // max tie goes to the later index
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 2, 2);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 3, 4);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 7, 8);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 5, 3);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 0, 4);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 9);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 2047, 2047);
        issue_cmd(srq_pkg::FUNC_LOAD, -7, 0, 0);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 2);
        wait_drained(4);
        set_mode(1'b1);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 9);    // the late load and the mode write left the table unbuilt
        issue_cmd(srq_pkg::FUNC_BUILD, 0, 0, 0);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, 9);    // min tie goes to the earlier index
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 7, 9);

        phase = 0;
        while (issued < 900)
        begin
            wait_drained(4);
            set_mode(1'($urandom_range(0, 1)));
            steady = (phase == 4);
            n_loads = $urandom_range(0, 60);
            repeat (n_loads)
            begin
                issue_cmd(srq_pkg::FUNC_LOAD, random_value(), $urandom_range(0, 2047),
                          $urandom_range(0, 2047));
            end
            issue_cmd(srq_pkg::FUNC_BUILD, $urandom, $urandom_range(0, 2047),
                      $urandom_range(0, 2047));
            n_queries = $urandom_range(6, 24);
            repeat (n_queries)
            begin
                if ($urandom_range(0, 99) < 15 || loaded == 0)
                begin
                    stray_cmd();
                end
                else
                begin
                    if (!built && $urandom_range(0, 1))
                        issue_cmd(srq_pkg::FUNC_BUILD, 0, 0, 0);
                    query_inside();
                end
            end
            phase++;
        end
        steady = 1'b0;

        // fill the store, push past it, then query the full table
        wait_drained(4);
        set_mode(1'($urandom_range(0, 1)));
        while (loaded < srq_pkg::CAPACITY)
            issue_cmd(srq_pkg::FUNC_LOAD, random_value(), 0, 0);
        repeat (3) issue_cmd(srq_pkg::FUNC_LOAD, random_value(), 0, 0);
        issue_cmd(srq_pkg::FUNC_BUILD, 0, 0, 0);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, srq_pkg::CAPACITY);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, srq_pkg::CAPACITY, srq_pkg::CAPACITY);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, srq_pkg::CAPACITY / 2 + 1, srq_pkg::CAPACITY);
        issue_cmd(srq_pkg::FUNC_QUERY, 0, 1, srq_pkg::CAPACITY + 1);
        repeat (20)
        begin
            if ($urandom_range(0, 99) < 15)
                stray_cmd();
            else
                query_inside();
        end
        wait_drained(40);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/srq_pkg.sv
rtl/core/srq_if.sv
rtl/core/srq_level_mem.sv
rtl/core/sparse_table_range_extreme_query_core.sv
tb/srq_checker.sv
tb/tb_sparse_table_range_extreme_query_core.sv
